>>> sv/lmsp_pkg.sv
// Shared widths, register codes and width helpers for the LMS adaptive predictor.
// No dependencies; imported by the interfaces, the weight update unit and the core.
package lmsp_pkg;

  localparam int LMSP_TAPS  = 20;
  localparam int SAMPLE_W   = 16;
  localparam int WEIGHT_W   = 24;
  localparam int STEP_W     = 16;
  localparam int PROD_W     = SAMPLE_W + WEIGHT_W;
  localparam int ACC_SHIFT  = 22;
  localparam int UPD_SHIFT  = 24;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_WEIGHT = 1'b1;

  localparam logic [STEP_W-1:0]          STEP_RESET        = 16'd655;
  localparam logic signed [WEIGHT_W-1:0] INIT_WEIGHT_RESET = 24'sd209715;

  localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // Dot-product accumulator: one product plus headroom for the tap count
  function automatic int lmsp_acc_w(input int taps);
    return PROD_W + 1 + $clog2(taps);
  endfunction

  // Prediction error, prediction minus sample
  function automatic int lmsp_err_w(input int taps);
    return lmsp_acc_w(taps) - ACC_SHIFT + 1;
  endfunction

  // Step size times error
  function automatic int lmsp_me_w(input int taps);
    return lmsp_err_w(taps) + STEP_W + 1;
  endfunction

  // Full weight correction before rounding
  function automatic int lmsp_d_w(input int taps);
    return lmsp_me_w(taps) + SAMPLE_W;
  endfunction

endpackage

>>> sv/lmsp_ifs.sv
// Valid/ready stream interfaces for sample input and prediction output.
// Depends on lmsp_pkg for field widths.
interface lmsp_in_if
  import lmsp_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface lmsp_out_if
  import lmsp_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] predicted;
  logic                       saturated;

  modport source (output valid, output predicted, output saturated, input ready);
  modport sink   (input valid, input predicted, input saturated, output ready);
endinterface

>>> sv/lmsp_wupd.sv
// Weight update datapath: round the correction, subtract it, clamp to Q2.22.
// Depends on lmsp_pkg for widths and weight limits.
module lmsp_wupd
  import lmsp_pkg::*;
#(
  parameter int TAPS = LMSP_TAPS
) (
  input  logic signed [lmsp_d_w(TAPS)-1:0] corr,
  input  logic signed [WEIGHT_W-1:0]       w_old,
  output logic signed [WEIGHT_W-1:0]       w_new
);

  localparam int D_W    = lmsp_d_w(TAPS);
  localparam int RS_W   = D_W - UPD_SHIFT;
  localparam int DIFF_W = RS_W + 1;
  localparam logic signed [D_W-1:0] HALF = D_W'(1) << (UPD_SHIFT - 1);

  logic signed [D_W-1:0]    corr_sum;
  logic signed [RS_W-1:0]   corr_rs;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-WEIGHT_W:0] top_bits;
  logic                     ovf;

  // round half up, then floor
  assign corr_sum = corr + HALF;
  assign corr_rs  = corr_sum[D_W-1:UPD_SHIFT];
  assign diff     = DIFF_W'(w_old) - DIFF_W'(corr_rs);

  // out of range when the bits above the weight's sign disagree
  assign top_bits = diff[DIFF_W-1:WEIGHT_W-1];
  assign ovf      = (|top_bits) && !(&top_bits);

  always_comb begin
    if (ovf) begin
      w_new = diff[DIFF_W-1] ? WEIGHT_MIN : WEIGHT_MAX;
    end else begin
      w_new = diff[WEIGHT_W-1:0];
    end
  end

endmodule

>>> sv/lms_adaptive_predictor_core.sv
// LMS adaptive predictor core: accepts a new sample only after the previous result has
// been loaded into the output register. Each sample takes two passes of the shared tap
// multiplier over the one-read-port history and weight memories.
// Reset (synchronous, rst_n low): history reads zero, every weight reads initial_weight
// through per-entry valid bits; no clearing pass. Writing initial_weight drops the weight
// valid bits. Depends on lmsp_pkg, lmsp_ifs and lmsp_wupd.
module lms_adaptive_predictor_core
  import lmsp_pkg::*;
#(
  parameter int TAPS = LMSP_TAPS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  lmsp_in_if.sink               in_s,
  lmsp_out_if.source            out_s
);

  localparam int AW     = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int ACC_W  = lmsp_acc_w(TAPS);
  localparam int ERR_W  = lmsp_err_w(TAPS);
  localparam int ME_W   = lmsp_me_w(TAPS);
  localparam int D_W    = lmsp_d_w(TAPS);
  localparam int PRED_W = ACC_W - ACC_SHIFT;

  localparam logic [AW-1:0]          LAST_IDX = AW'(TAPS - 1);
  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (ACC_SHIFT - 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // wait for a sample transfer
  localparam logic [2:0] S_RD1  = 3'd1;  // issue reads, dot product with old weights
  localparam logic [2:0] S_DR1  = 3'd2;  // drain first pass
  localparam logic [2:0] S_ERR  = 3'd3;  // prediction and error
  localparam logic [2:0] S_MU   = 3'd4;  // step size times error
  localparam logic [2:0] S_RD2  = 3'd5;  // issue reads, update weights, new dot product
  localparam logic [2:0] S_DR2  = 3'd6;  // drain second pass
  localparam logic [2:0] S_OUT  = 3'd7;  // load result, shift sample into history

  logic [2:0] state_r, state_nxt;

  // Configuration registers
  logic [STEP_W-1:0]          step_r;
  logic signed [WEIGHT_W-1:0] init_w_r;

  // Memories and their per-entry valid bits
  logic signed [WEIGHT_W-1:0] w_mem_r [TAPS];
  logic signed [SAMPLE_W-1:0] h_mem_r [TAPS];
  logic [TAPS-1:0]            wvld_r;
  logic [TAPS-1:0]            hvld_r;

  // Sequencing
  logic [AW-1:0]              cnt_r;
  logic [AW-1:0]              haddr_r;
  logic [AW-1:0]              hptr_r;
  logic [AW-1:0]              hptr_dec;
  logic signed [SAMPLE_W-1:0] x_r;
  logic                       in_xfer;
  logic                       issue;
  logic                       pass2;
  logic                       drained;
  logic                       out_free;
  logic                       hist_wr;

  // Tap pipeline
  logic signed [WEIGHT_W-1:0] w_q_r;
  logic signed [SAMPLE_W-1:0] h_q_r;
  logic                       wv_q_r;
  logic                       hv_q_r;
  logic                       s1_v_r;
  logic [AW-1:0]              s1_k_r;
  logic signed [SAMPLE_W-1:0] h1;
  logic signed [WEIGHT_W-1:0] w1;
  logic signed [D_W-1:0]      d_r;
  logic signed [SAMPLE_W-1:0] h2_r;
  logic signed [WEIGHT_W-1:0] w2_r;
  logic [AW-1:0]              k2_r;
  logic                       s2_v_r;
  logic signed [WEIGHT_W-1:0] w_upd;
  logic signed [SAMPLE_W-1:0] h3_r;
  logic signed [WEIGHT_W-1:0] w3_r;
  logic                       s3_v_r;
  logic signed [SAMPLE_W-1:0] mul_a;
  logic signed [WEIGHT_W-1:0] mul_b;
  logic                       mul_v;
  logic signed [PROD_W-1:0]   prod_r;
  logic                       prod_v_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic                       acc_clr;

  // Error path and result
  logic signed [ACC_W-1:0]    acc_rnd;
  logic signed [PRED_W-1:0]   pred;
  logic signed [ERR_W-1:0]    err_r;
  logic signed [ME_W-1:0]     me_r;
  logic [PRED_W-SAMPLE_W:0]   y_top;
  logic                       y_ovf;
  logic signed [SAMPLE_W-1:0] y_sat;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_pred_r;
  logic                       out_sat_r;

  // ---------------------------------------------------------------------------
  // Handshakes and control strobes
  // ---------------------------------------------------------------------------
  assign in_s.ready = (state_r == S_IDLE);
  assign in_xfer    = in_s.valid && in_s.ready;
  assign issue      = (state_r == S_RD1) || (state_r == S_RD2);
  assign pass2      = (state_r == S_RD2) || (state_r == S_DR2);
  assign drained    = !(s1_v_r || s2_v_r || s3_v_r || prod_v_r);
  assign out_free   = !out_valid_r || out_s.ready;
  assign hist_wr    = (state_r == S_OUT) && out_free;
  assign acc_clr    = in_xfer || (state_r == S_MU);
  // history[0] moves one slot down the ring on every new sample
  assign hptr_dec   = (hptr_r == '0) ? LAST_IDX : hptr_r - 1'b1;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_xfer) state_nxt = S_RD1;
      S_RD1:  if (cnt_r == LAST_IDX) state_nxt = S_DR1;
      S_DR1:  if (drained) state_nxt = S_ERR;
      S_ERR:  state_nxt = S_MU;
      S_MU:   state_nxt = S_RD2;
      S_RD2:  if (cnt_r == LAST_IDX) state_nxt = S_DR2;
      S_DR2:  if (drained) state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      haddr_r <= '0;
      hptr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      // restart both address walks at the head of each pass
      if (acc_clr) begin
        cnt_r   <= '0;
        haddr_r <= hptr_r;
      end else if (issue) begin
        cnt_r   <= cnt_r + 1'b1;
        haddr_r <= (haddr_r == LAST_IDX) ? '0 : haddr_r + 1'b1;
      end
      if (hist_wr) begin
        hptr_r <= hptr_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      x_r <= in_s.sample;
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= STEP_RESET;
      init_w_r <= INIT_WEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_STEP_SIZE:   step_r   <= cfg_wdata[STEP_W-1:0];
        CFG_INIT_WEIGHT: init_w_r <= cfg_wdata[WEIGHT_W-1:0];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Memories: one read per cycle each, registered read data.
  // Weights are indexed by tap; history is a ring with hptr_r at history[0].
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (issue) begin
      w_q_r  <= w_mem_r[cnt_r];
      h_q_r  <= h_mem_r[haddr_r];
      wv_q_r <= wvld_r[cnt_r];
      hv_q_r <= hvld_r[haddr_r];
      s1_k_r <= cnt_r;
    end
    if (s2_v_r) begin
      w_mem_r[k2_r] <= w_upd;
    end
    if (hist_wr) begin
      h_mem_r[hptr_dec] <= x_r;
    end
  end

  // Valid bits: an unwritten history slot reads zero, an unwritten weight reads
  // the initial weight. A write of initial_weight reloads every weight at once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wvld_r <= '0;
      hvld_r <= '0;
    end else begin
      if (cfg_we && (cfg_idx == CFG_INIT_WEIGHT)) begin
        wvld_r <= '0;
      end else if (s2_v_r) begin
        wvld_r[k2_r] <= 1'b1;
      end
      if (hist_wr) begin
        hvld_r[hptr_dec] <= 1'b1;
      end
    end
  end

  assign h1 = hv_q_r ? h_q_r : '0;
  assign w1 = wv_q_r ? w_q_r : init_w_r;

  // ---------------------------------------------------------------------------
  // Tap pipeline
  //   pass 1: read -> product -> accumulate
  //   pass 2: read -> correction product -> new weight (write back) -> product
  //           -> accumulate
  // The tap multiplier is shared: pass 1 feeds it from the read stage, pass 2
  // from the updated weight stage. Each pass touches every weight once, so a
  // write back never meets a read of the same entry.
  // ---------------------------------------------------------------------------
  lmsp_wupd #(
    .TAPS (TAPS)
  ) u_wupd (
    .corr  (d_r),
    .w_old (w2_r),
    .w_new (w_upd)
  );

  assign mul_a = pass2 ? h3_r   : h1;
  assign mul_b = pass2 ? w3_r   : w1;
  assign mul_v = pass2 ? s3_v_r : s1_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      s3_v_r   <= 1'b0;
      prod_v_r <= 1'b0;
    end else begin
      s1_v_r   <= issue;
      s2_v_r   <= s1_v_r && pass2;
      s3_v_r   <= s2_v_r;
      prod_v_r <= mul_v;
    end
  end

  always_ff @(posedge clk) begin
    d_r    <= h1 * me_r;
    h2_r   <= h1;
    w2_r   <= w1;
    k2_r   <= s1_k_r;
    h3_r   <= h2_r;
    w3_r   <= w_upd;
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (acc_clr) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction, error and step-scaled error
  // ---------------------------------------------------------------------------
  // round half up, then floor: the upper bits of the biased sum
  assign acc_rnd = acc_r + ACC_HALF;
  assign pred    = acc_rnd[ACC_W-1:ACC_SHIFT];

  always_ff @(posedge clk) begin
    if (state_r == S_ERR) begin
      err_r <= ERR_W'(pred) - ERR_W'(x_r);
    end
    if (state_r == S_MU) begin
      me_r <= $signed({1'b0, step_r}) * err_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Result: clamp to Q1.15, hold in the output register until transferred
  // ---------------------------------------------------------------------------
  assign y_top = pred[PRED_W-1:SAMPLE_W-1];
  assign y_ovf = (|y_top) && !(&y_top);

  always_comb begin
    if (y_ovf) begin
      y_sat = pred[PRED_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
    end else begin
      y_sat = pred[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (hist_wr) begin
      out_valid_r <= 1'b1;
    end else if (out_s.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hist_wr) begin
      out_pred_r <= y_sat;
      out_sat_r  <= y_ovf;
    end
  end

  assign out_s.valid     = out_valid_r;
  assign out_s.predicted = out_pred_r;
  assign out_s.saturated = out_sat_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> drained)
    else $error("tap pipeline still busy while idle");

  a_wb_in_pass2: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> (state_r == S_RD2 || state_r == S_DR2))
    else $error("weight write back outside the update pass");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> (cnt_r <= LAST_IDX))
    else $error("tap counter beyond last tap");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("result loaded outside the output step");

  a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sat_r) |-> (out_pred_r == SAMPLE_MAX || out_pred_r == SAMPLE_MIN))
    else $error("saturated flag set on an unclipped result");

endmodule

>>> sim/tb.sv
// Self-checking bench for lms_adaptive_predictor_core: drives samples, tracks the adaptive
// filter state in a behavioural predictor and compares every transfer on the result channel.
// Depends on lmsp_pkg, lmsp_ifs and the core RTL.
module tb;
  import lmsp_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 2 * LMSP_TAPS + 12;  // one full sample slot of the core
  localparam int LONG_HOLD   = 900;
  localparam int PHASE_ITEMS = 260;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] predicted;
    logic                       saturated;
  } estimate_t;

  typedef enum int {SIG_NOISE, SIG_WALK, SIG_QUIET} signal_kind_t;
  typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_PATTERN} sink_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  lmsp_in_if  in_ch ();
  lmsp_out_if out_ch ();

  lms_adaptive_predictor_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_s      (in_ch),
    .out_s     (out_ch)
  );

  // Filter state as the core should hold it
  logic signed [SAMPLE_W-1:0] tap_history [LMSP_TAPS];
  logic signed [WEIGHT_W-1:0] tap_weight  [LMSP_TAPS];
  logic [STEP_W-1:0]          mu_reg;
  logic signed [WEIGHT_W-1:0] weight_seed;

  estimate_t pending_estimates [$];
  int        mismatches = 0;
  int        cycle_count = 0;
  int        holds_requested = 0;
  int        holds_served = 0;
  int        burst_left = 0;
  logic signed [SAMPLE_W-1:0] walk_level = '0;

  always #6 clk = ~clk;

  // Abandon the run if it hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Add half an LSB, then floor (arithmetic shift)
  function automatic longint round_down_shift(longint v, int sh);
    longint t;
    t = v + (longint'(1) << (sh - 1));
    return t >>> sh;
  endfunction

  function automatic longint history_dot_weights();
    longint acc;
    acc = 0;
    for (int k = 0; k < LMSP_TAPS; k++)
      acc += longint'(tap_history[k]) * longint'(tap_weight[k]);
    return acc;
  endfunction

  task automatic reload_weights();
    for (int k = 0; k < LMSP_TAPS; k++)
      tap_weight[k] = weight_seed;
  endtask

  // Predict, adapt every weight against the error, filter again, then shift the sample in
  task automatic adapt_and_estimate(input logic signed [SAMPLE_W-1:0] x, output estimate_t est);
    longint guess, err, corr, w, y;
    guess = round_down_shift(history_dot_weights(), ACC_SHIFT);
    err   = guess - longint'(x);
    for (int k = 0; k < LMSP_TAPS; k++) begin
      corr = longint'(mu_reg) * longint'(tap_history[k]) * err;
      w    = longint'(tap_weight[k]) - round_down_shift(corr, UPD_SHIFT);
      if (w > longint'(WEIGHT_MAX)) w = longint'(WEIGHT_MAX);
      if (w < longint'(WEIGHT_MIN)) w = longint'(WEIGHT_MIN);
      tap_weight[k] = w[WEIGHT_W-1:0];
    end
    y = round_down_shift(history_dot_weights(), ACC_SHIFT);
    est.saturated = 1'b0;
    if (y > longint'(SAMPLE_MAX)) begin
      y = longint'(SAMPLE_MAX);
      est.saturated = 1'b1;
    end else if (y < longint'(SAMPLE_MIN)) begin
      y = longint'(SAMPLE_MIN);
      est.saturated = 1'b1;
    end
    est.predicted = y[SAMPLE_W-1:0];
    for (int k = LMSP_TAPS - 1; k > 0; k--)
      tap_history[k] = tap_history[k-1];
    tap_history[0] = x;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one sample; open a random gap first when the current burst is spent.
  // The predictor advances at the edge where the transfer happens.
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] x);
    int gap;
    estimate_t est;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid  = 1'b1;
    in_ch.sample = x;
    do @(posedge clk); while (!in_ch.ready);
    adapt_and_estimate(x, est);
    pending_estimates.push_back(est);
  endtask

  // Drop valid, wait for every outstanding result, then let one sample slot pass
  task automatic drain_core();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_STEP_SIZE: begin
        mu_reg = data[STEP_W-1:0];
      end
      CFG_INIT_WEIGHT: begin
        weight_seed = data;
        reload_weights();
      end
      default: ;
    endcase
  endtask

  // Correlated random walk so the weights settle, full-scale raw noise, or quiet low-level noise
  function automatic logic signed [SAMPLE_W-1:0] next_signal(signal_kind_t kind);
    int lvl;
    case (kind)
      SIG_NOISE: return SAMPLE_W'($urandom_range(0, 65535));
      SIG_QUIET: return SAMPLE_W'(int'($urandom_range(0, 1023)) - 512);
      default: begin
        lvl = int'(walk_level) + int'($urandom_range(0, 2047)) - 1024;
        if (lvl > int'(SAMPLE_MAX)) lvl = int'(SAMPLE_MAX);
        if (lvl < int'(SAMPLE_MIN)) lvl = int'(SAMPLE_MIN);
        walk_level = lvl[SAMPLE_W-1:0];
        return walk_level;
      end
    endcase
  endfunction

  function automatic signal_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return SIG_NOISE;
    if (r < 8) return SIG_WALK;
    return SIG_QUIET;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Receiver: switch between open, random and fixed-pattern stalls; serve long holds on request
  initial begin : result_sink
    sink_mode_t mode;
    int left;
    int beat;
    mode = SINK_OPEN;
    left = 0;
    beat = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served < holds_requested) begin
        out_ch.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        holds_served++;
      end else begin
        if (left == 0) begin
          mode = sink_mode_t'($urandom_range(0, 2));
          left = $urandom_range(50, 300);
        end
        left--;
        beat++;
        case (mode)
          SINK_OPEN:   out_ch.ready = 1'b1;
          SINK_RANDOM: out_ch.ready = 1'($urandom_range(0, 1));
          default:     out_ch.ready = (beat % 7) < 3;
        endcase
      end
    end
  end

  // Compare each result transfer with the oldest estimate
  always @(posedge clk) begin
    estimate_t want;
    estimate_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.predicted = out_ch.predicted;
      got.saturated = out_ch.saturated;
      if (pending_estimates.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: predicted=%0d saturated=%0b",
                   got.predicted, got.saturated);
      end else begin
        want = pending_estimates.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display({"result mismatch: expected predicted=%0d saturated=%0b, ",
                      "got predicted=%0d saturated=%0b"},
                     want.predicted, want.saturated, got.predicted, got.saturated);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes and alternating bit patterns under the reset settings
  task automatic test_reset_defaults();
    push_sample(16'sd0);
    push_sample(SAMPLE_MAX);
    push_sample(SAMPLE_MIN);
    push_sample(-16'sd1);
    push_sample(16'sd1);
    push_sample(16'sh5555);
    push_sample(16'shAAAA);
    drain_core();
  endtask

  // Freeze adaptation and load extreme weights to clip the output high, then low
  task automatic test_output_clipping();
    write_reg(CFG_STEP_SIZE, {8'h00, 16'd0});
    write_reg(CFG_INIT_WEIGHT, WEIGHT_MAX);
    repeat (4) push_sample(SAMPLE_MAX);
    drain_core();
    write_reg(CFG_INIT_WEIGHT, WEIGHT_MIN);
    repeat (3) push_sample(SAMPLE_MAX);
    drain_core();
  endtask

  // Largest step against full-scale swings drives the weights into their limits
  task automatic test_weight_clamping();
    write_reg(CFG_STEP_SIZE, {8'hFF, 16'hFFFF});
    write_reg(CFG_INIT_WEIGHT, WEIGHT_MAX);
    repeat (3) begin
      push_sample(SAMPLE_MIN);
      push_sample(SAMPLE_MAX);
    end
    drain_core();
  endtask

  // Several register settings, each followed by a long run of random signal.
  // The first phase rewrites only the step, so weights and history carry over.
  task automatic test_adaptation_phases();
    signal_kind_t kind;
    int run;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_reg(CFG_STEP_SIZE, {8'($urandom), 16'($urandom_range(1, 2000))});
        1: begin
          write_reg(CFG_STEP_SIZE, {8'($urandom), 16'd0});
          write_reg(CFG_INIT_WEIGHT, 24'($urandom));
        end
        2: begin
          write_reg(CFG_STEP_SIZE, {8'($urandom), 16'hFFFF});
          write_reg(CFG_INIT_WEIGHT, WEIGHT_MIN);
        end
        3: begin
          write_reg(CFG_INIT_WEIGHT, 24'($urandom_range(0, 600000)) - 24'd300000);
          write_reg(CFG_STEP_SIZE, {8'($urandom), 16'($urandom)});
        end
        4: begin
          write_reg(CFG_STEP_SIZE, {8'($urandom), 16'd1});
          write_reg(CFG_INIT_WEIGHT, WEIGHT_MAX);
        end
        default: begin
          write_reg(CFG_STEP_SIZE, {8'h00, STEP_RESET});
          write_reg(CFG_INIT_WEIGHT, 24'd0);
        end
      endcase
      kind = SIG_WALK;
      run  = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold one signal style for a stretch, then pick again
        if (run == 0) begin
          kind = pick_kind();
          run  = $urandom_range(5, 60);
        end
        run--;
        push_sample(next_signal(kind));
      end
      drain_core();
    end
  endtask

  // Block the result side for a long stretch while samples keep coming, so the core
  // backs up and stalls its input
  task automatic test_result_backpressure();
    write_reg(CFG_STEP_SIZE, {8'h00, STEP_RESET});
    holds_requested++;
    for (int n = 0; n < 40; n++)
      push_sample(next_signal(pick_kind()));
    while (holds_served < holds_requested) @(posedge clk);
    drain_core();
  endtask

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    mu_reg       = STEP_RESET;
    weight_seed  = INIT_WEIGHT_RESET;
    for (int k = 0; k < LMSP_TAPS; k++)
      tap_history[k] = '0;
    reload_weights();

    // hold reset, then release it on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_output_clipping();
    test_weight_clamping();
    test_adaptation_phases();
    test_result_backpressure();

    if (mismatches == 0 && pending_estimates.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> sim.f
sv/lmsp_pkg.sv
sv/lmsp_ifs.sv
sv/lmsp_wupd.sv
sv/lms_adaptive_predictor_core.sv
sim/tb.sv
